// File: rtl/skt_pkg.sv
// shared constants, codes and types of the sorted key table
package skt_pkg;

   // table geometry
   localparam int DEPTH       = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int HANDLE_BITS = 16;
   localparam int KIND_W      = 2;
   localparam int STAT_W      = 3;

   // stream word widths
   localparam int REQ_FIELDS_W = KEY_W + HANDLE_BITS + IDX_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STAT_W + IDX_W + KEY_W + HANDLE_BITS + CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_ADDED   = 3'd0;
   localparam logic [STAT_W-1:0] STAT_UPDATED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FOUND   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_MISSING = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_PLACE,
      ST_FETCH,
      ST_MOVE,
      ST_FINISH
   } state_type;

   // access to the entry store
   typedef struct packed {
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_addr;
      logic signed [KEY_W-1:0] wr_key;
      logic [HANDLE_BITS-1:0]  wr_pay;
      logic                    rd_en;
      logic [IDX_W-1:0]        rd_addr;
   } mem_req_type;

endpackage

// File: rtl/sorted_key_table_core.sv
// sorted key table: sequencer, entry count and stream ports
//
// Keeps up to 64 entries (signed 32-bit key, 16-bit handle) in ascending key
// order in a single-port-read, single-port-write store.
// req channel: one word per request; tuser carries the operation kind
// (add, lookup, remove at position, access at position).
// rsp channel: exactly one word per request, in request order.
// csr port: csr_wr_en writes the capacity; write it only while idle.
// One request is worked at a time; req_tready is high only when idle.
// Work per request (n = entries held), with at most one store read per step:
//   lookup / add of present key: search upward from entry 0
//   add of new key: search all n entries, then shift larger entries up one place
//   remove: read the entry, then entries after the position move down one per cycle
//   access: read the entry at the position
// After reset the table is empty and capacity is 64.
// A stalled rsp keeps its word; the next result waits in the finish step.
module sorted_key_table_core (
   input  logic                               clock,
   input  logic                               reset,
   // fields from bit 0: key_id[31:0], payload[47:32], position[53:48], zero pad
   input  logic [skt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // fields from bit 0: kind[1:0]
   input  logic [skt_pkg::KIND_W-1:0]         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // fields from bit 0: status[2:0], found_position[8:3], out_key[40:9],
   // out_payload[56:41], entry_count[63:57]
   output logic [skt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wr_en,
   input  logic [skt_pkg::CNT_W-1:0]          csr_wr_data
);
   import skt_pkg::*;

   state_type                state_ff, state_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic [HANDLE_BITS-1:0]   pay_ff, pay_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cap_ff;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [IDX_W-1:0]         fpos_ff, fpos_in;
   logic signed [KEY_W-1:0]  okey_ff, okey_in;
   logic [HANDLE_BITS-1:0]   opay_ff, opay_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   mem_req_type              mem_req;
   logic signed [KEY_W-1:0]  rd_key;
   logic [HANDLE_BITS-1:0]   rd_pay;

   logic                     req_fire;
   logic [CNT_W-1:0]         cap_eff;
   logic [CNT_W-1:0]         idx_ext;
   logic [CNT_W-1:0]         pos_ext;
   logic signed [KEY_W-1:0]  req_key;
   logic [HANDLE_BITS-1:0]   req_pay;
   logic [IDX_W-1:0]         req_pos;

   skt_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_key  (rd_key),
      .rd_pay  (rd_pay)
   );

   // request fields and helpers
   assign req_key  = req_tdata[KEY_W-1:0];
   assign req_pay  = req_tdata[KEY_W+HANDLE_BITS-1:KEY_W];
   assign req_pos  = req_tdata[REQ_FIELDS_W-1:KEY_W+HANDLE_BITS];
   assign req_fire = req_tvalid && req_tready;
   assign cap_eff  = (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;
   assign idx_ext  = CNT_W'(idx_ff);
   assign pos_ext  = CNT_W'(pos_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CNT_W'(DEPTH);
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      fpos_ff     <= fpos_in;
      okey_ff     <= okey_in;
      opay_ff     <= opay_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: at most one store read and at most one store write per cycle
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      fpos_in      = fpos_ff;
      okey_in      = okey_ff;
      opay_in      = opay_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_tuser;
               key_in    = req_key;
               pay_in    = req_pay;
               pos_in    = req_pos;
               status_in = STAT_MISSING;
               fpos_in   = '0;
               okey_in   = '0;
               opay_in   = '0;
               idx_in    = '0;
               if (req_tuser == KIND_ADD || req_tuser == KIND_LOOKUP) begin
                  if (count_ff != '0) begin
                     // start the key search at entry 0
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     state_in        = ST_SCAN;
                  end else if (req_tuser == KIND_LOOKUP) begin
                     state_in = ST_FINISH;
                  end else if (count_ff >= cap_eff) begin
                     status_in = STAT_FULL;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in = ST_PLACE;
                  end
               end else if (CNT_W'(req_pos) < count_ff) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = req_pos;
                  state_in        = ST_FETCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            // read data holds entry idx
            if (rd_key == key_ff) begin
               fpos_in  = idx_ff;
               state_in = ST_FINISH;
               if (kind_ff == KIND_ADD) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = idx_ff;
                  mem_req.wr_key  = key_ff;
                  mem_req.wr_pay  = pay_ff;
                  status_in       = STAT_UPDATED;
               end else begin
                  status_in = STAT_FOUND;
               end
            end else if (idx_ext + CNT_W'(1) < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + IDX_W'(1);
               idx_in          = idx_ff + IDX_W'(1);
            end else if (kind_ff == KIND_LOOKUP) begin
               state_in = ST_FINISH;
            end else if (count_ff >= cap_eff) begin
               status_in = STAT_FULL;
               state_in  = ST_FINISH;
            end else begin
               // new key: walk down from the top entry
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(count_ff - CNT_W'(1));
               idx_in          = IDX_W'(count_ff);
               state_in        = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // read data holds entry idx - 1
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            if (key_ff < rd_key) begin
               mem_req.wr_key = rd_key;
               mem_req.wr_pay = rd_pay;
               idx_in         = idx_ff - IDX_W'(1);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff - IDX_W'(2);
               end
            end else begin
               mem_req.wr_key = key_ff;
               mem_req.wr_pay = pay_ff;
               count_in       = count_ff + CNT_W'(1);
               status_in      = STAT_ADDED;
               state_in       = ST_FINISH;
            end
         end

         ST_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_key  = key_ff;
            mem_req.wr_pay  = pay_ff;
            count_in        = count_ff + CNT_W'(1);
            status_in       = STAT_ADDED;
            state_in        = ST_FINISH;
         end

         ST_FETCH: begin
            // read data holds entry pos
            okey_in   = rd_key;
            opay_in   = rd_pay;
            status_in = STAT_FOUND;
            if (kind_ff == KIND_ACCESS) begin
               state_in = ST_FINISH;
            end else if (pos_ext + CNT_W'(1) < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pos_ff + IDX_W'(1);
               idx_in          = pos_ff;
               state_in        = ST_MOVE;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end
         end

         ST_MOVE: begin
            // read data holds entry idx + 1, moved down into idx
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_key  = rd_key;
            mem_req.wr_pay  = rd_pay;
            if (idx_ext + CNT_W'(2) < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + IDX_W'(2);
               idx_in          = idx_ff + IDX_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hand the result word to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({count_ff, opay_ff, okey_ff, fpos_ff, status_ff});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   // the entry count never passes the built depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // the store is never written while idle or while finishing
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff != ST_IDLE && state_ff != ST_FINISH))
      else $error("store write outside an operation");

   // a new result word only comes from the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result word raised outside finish");

   // an accepted request always leaves idle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // an added entry leaves at least one entry in the table
   a_added_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[STAT_W-1:0] == STAT_ADDED)
         |-> rsp_data_ff[RSP_FIELDS_W-1:RSP_FIELDS_W-CNT_W] != '0)
      else $error("added result with empty table");
`endif

endmodule

// File: rtl/skt_mem.sv
// entry store: one write port and one registered read port
module skt_mem (
   input  logic                                clock,
   input  skt_pkg::mem_req_type                mem_req,
   output logic signed [skt_pkg::KEY_W-1:0]    rd_key,
   output logic [skt_pkg::HANDLE_BITS-1:0]     rd_pay
);
   import skt_pkg::*;

   logic signed [KEY_W-1:0] key_mem [DEPTH];
   logic [HANDLE_BITS-1:0]  pay_mem [DEPTH];
   logic signed [KEY_W-1:0] rd_key_ff;
   logic [HANDLE_BITS-1:0]  rd_pay_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_mem[mem_req.wr_addr] <= mem_req.wr_key;
         pay_mem[mem_req.wr_addr] <= mem_req.wr_pay;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_key_ff <= key_mem[mem_req.rd_addr];
         rd_pay_ff <= pay_mem[mem_req.rd_addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_pay = rd_pay_ff;

endmodule

// File: sim/sorted_key_table_core_tb.sv
// self-checking testbench for the sorted key table core
module sorted_key_table_core_tb;
   import skt_pkg::*;

   // request word as generated, kind travels on tuser
   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [IDX_W-1:0]        position;
      logic [HANDLE_BITS-1:0]  payload;
      logic signed [KEY_W-1:0] key_id;
   } key_req_t;

   // response word, msb field first so it maps straight onto rsp_tdata
   typedef struct packed {
      logic [CNT_W-1:0]        entry_count;
      logic [HANDLE_BITS-1:0]  out_payload;
      logic signed [KEY_W-1:0] out_key;
      logic [IDX_W-1:0]        found_pos;
      logic [STAT_W-1:0]       status;
   } key_rsp_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   // shadow of the table contents and capacity
   logic signed [KEY_W-1:0] held_keys [DEPTH];
   logic [HANDLE_BITS-1:0]  held_pays [DEPTH];
   int                      held_count = 0;
   int                      capacity_reg = 64;

   key_req_t                requests_waiting[$];
   key_rsp_t                answers_due[$];
   logic signed [KEY_W-1:0] key_pool[$];
   key_req_t                active_req = '0;
   logic                    req_taken = 1'b0;
   int                      stall_pct = 25;
   int                      error_count = 0;

   sorted_key_table_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow table and return the answer it earns
   function automatic key_rsp_t next_table_answer(input key_req_t r);
      key_rsp_t a;
      int       hit;
      int       i;
      int       room;
      a = '0;
      a.status = STAT_MISSING;
      room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      hit = -1;
      for (i = 0; i < held_count; i++) begin
         if (hit < 0 && held_keys[i] == r.key_id) hit = i;
      end
      case (r.kind)
         KIND_ADD: begin
            if (hit >= 0) begin
               held_pays[hit] = r.payload;
               a.status = STAT_UPDATED;
               a.found_pos = hit[IDX_W-1:0];
            end else if (held_count >= room) begin
               a.status = STAT_FULL;
            end else begin
               // open a slot by moving larger keys up one place
               i = held_count;
               while (i > 0 && r.key_id < held_keys[i-1]) begin
                  held_keys[i] = held_keys[i-1];
                  held_pays[i] = held_pays[i-1];
                  i--;
               end
               held_keys[i] = r.key_id;
               held_pays[i] = r.payload;
               held_count++;
               a.status = STAT_ADDED;
            end
         end
         KIND_LOOKUP: begin
            if (hit >= 0) begin
               a.status = STAT_FOUND;
               a.found_pos = hit[IDX_W-1:0];
            end
         end
         default: begin
            if (int'(r.position) < held_count) begin
               a.status = STAT_FOUND;
               a.out_key = held_keys[r.position];
               a.out_payload = held_pays[r.position];
               if (r.kind == KIND_REMOVE) begin
                  for (i = int'(r.position); i + 1 < held_count; i++) begin
                     held_keys[i] = held_keys[i+1];
                     held_pays[i] = held_pays[i+1];
                  end
                  held_count--;
               end
            end
         end
      endcase
      a.entry_count = held_count[CNT_W-1:0];
      return a;
   endfunction

   function automatic key_req_t mk_req(input logic [KIND_W-1:0] kind,
                                       input logic [KEY_W-1:0] key_id,
                                       input int payload,
                                       input int position);
      key_req_t r;
      r.kind = kind;
      r.key_id = key_id;
      r.payload = HANDLE_BITS'(payload);
      r.position = IDX_W'(position);
      return r;
   endfunction

   // random request; keys lean on recently added ones so hits are common
   function automatic key_req_t random_req(input int add_w, input int lookup_w,
                                           input int remove_w);
      key_req_t r;
      int       pick;
      int       sel;
      r.key_id = $urandom;
      r.payload = HANDLE_BITS'($urandom);
      r.position = IDX_W'($urandom);
      pick = $urandom_range(99);
      if (pick < add_w) r.kind = KIND_ADD;
      else if (pick < add_w + lookup_w) r.kind = KIND_LOOKUP;
      else if (pick < add_w + lookup_w + remove_w) r.kind = KIND_REMOVE;
      else r.kind = KIND_ACCESS;
      sel = $urandom_range(99);
      if (r.kind == KIND_ADD || r.kind == KIND_LOOKUP) begin
         if (sel < 45 && key_pool.size() > 0)
            r.key_id = key_pool[$urandom_range(key_pool.size() - 1)];
         else if (sel < 65)
            r.key_id = 32'($urandom_range(16)) - 32'd8;
         else if (sel < 75)
            r.key_id = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
         if (sel < 40) r.position = IDX_W'($urandom_range(7));
         else if (sel < 70) r.position = IDX_W'($urandom_range(31));
      end
      if (r.kind == KIND_ADD) begin
         key_pool.push_back(r.key_id);
         if (key_pool.size() > 96) void'(key_pool.pop_front());
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (want !== got) begin
         $display("%0t rsp %s: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // sender holds off until the table is idle and nothing is outstanding
   task automatic wait_idle();
      do @(posedge clock);
      while (requests_waiting.size() != 0 || req_tvalid || answers_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_capacity(input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CNT_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int cap, input int count, input int stall,
                             input int add_w, input int lookup_w, input int remove_w);
      wait_idle();
      set_capacity(cap);
      stall_pct = stall;
      repeat (count) requests_waiting.push_back(random_req(add_w, lookup_w, remove_w));
   endtask

   // request driver and response backpressure, both change on the falling edge
   always @(negedge clock) begin
      key_req_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (!req_tvalid || req_taken) begin
            if (requests_waiting.size() > 0 && $urandom_range(99) >= stall_pct) begin
               nxt = requests_waiting.pop_front();
               active_req <= nxt;
               req_tdata <= REQ_DATA_W'({nxt.position, nxt.payload, nxt.key_id});
               req_tuser <= nxt.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: track capacity writes, predict on accepted requests, check words
   always @(posedge clock) begin
      key_rsp_t want;
      key_rsp_t got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready === 1'b1;
         if (csr_wr_en) capacity_reg = int'(csr_wr_data);
         if (req_tvalid && req_tready === 1'b1)
            answers_due.push_back(next_table_answer(active_req));
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got = key_rsp_t'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (answers_due.size() == 0) begin
               $display("%0t rsp word with nothing expected: expected none, actual %0h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", KEY_W'(want.status), KEY_W'(got.status));
               check_field("found_position", KEY_W'(want.found_pos),
                           KEY_W'(got.found_pos));
               check_field("out_key", want.out_key, got.out_key);
               check_field("out_payload", KEY_W'(want.out_payload),
                           KEY_W'(got.out_payload));
               check_field("entry_count", KEY_W'(want.entry_count),
                           KEY_W'(got.entry_count));
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_capacity(64);

      // empty table, extreme keys, sorted inserts, update, hits and misses
      requests_waiting.push_back(mk_req(KIND_ACCESS, 0, 0, 0));
      requests_waiting.push_back(mk_req(KIND_REMOVE, 0, 0, 63));
      requests_waiting.push_back(mk_req(KIND_LOOKUP, 0, 0, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'h7FFF_FFFF, 16'hFFFF, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'h8000_0000, 16'h0000, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'h0000_0000, 16'h1234, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'hFFFF_FFFF, 16'hAAAA, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'h0000_0000, 16'h5555, 0));
      requests_waiting.push_back(mk_req(KIND_LOOKUP, 32'h8000_0000, 0, 0));
      requests_waiting.push_back(mk_req(KIND_LOOKUP, 32'h7FFF_FFFF, 0, 0));
      requests_waiting.push_back(mk_req(KIND_LOOKUP, 32'd12345, 0, 0));
      requests_waiting.push_back(mk_req(KIND_ACCESS, 0, 0, 3));
      requests_waiting.push_back(mk_req(KIND_ACCESS, 0, 0, 4));
      requests_waiting.push_back(mk_req(KIND_REMOVE, 0, 0, 1));
      requests_waiting.push_back(mk_req(KIND_REMOVE, 0, 0, 3));

      // capacity below the count: new keys rejected, present keys still update
      wait_idle();
      set_capacity(2);
      requests_waiting.push_back(mk_req(KIND_ADD, 32'd7, 16'h0F0F, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'd0, 16'h00FF, 0));
      requests_waiting.push_back(mk_req(KIND_REMOVE, 0, 0, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'd9, 16'h0001, 0));

      // zero capacity always full, position past the count, drain to empty
      wait_idle();
      set_capacity(0);
      requests_waiting.push_back(mk_req(KIND_ADD, 32'd1, 16'h8000, 0));
      requests_waiting.push_back(mk_req(KIND_LOOKUP, 32'h7FFF_FFFF, 0, 0));
      requests_waiting.push_back(mk_req(KIND_ACCESS, 0, 0, 63));
      requests_waiting.push_back(mk_req(KIND_REMOVE, 0, 0, 0));
      requests_waiting.push_back(mk_req(KIND_REMOVE, 0, 0, 0));
      requests_waiting.push_back(mk_req(KIND_ADD, 32'd3, 16'h0002, 0));

      // random phases over several capacities, one with no stalls at all
      run_random(127, 150, 25, 70, 10, 10);
      run_random(64, 120, 0, 25, 25, 30);
      run_random(5, 100, 25, 40, 20, 20);
      run_random(1, 60, 25, 40, 20, 20);
      run_random(64, 130, 25, 20, 20, 45);
      run_random(37, 140, 25, 45, 20, 15);

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0 && answers_due.size() == 0) begin
         $display("sorted_key_table_core_tb: clean");
      end else begin
         $display("sorted_key_table_core_tb: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("sorted_key_table_core_tb: errors");
      $finish;
   end

endmodule
